### rtl/core/kpc_pkg.sv
`timescale 1ns / 1ps

package kpc_pkg;

  // Field widths
  localparam int unsigned CODE_W  = 6;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned KEY_W   = 3;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Key line codes (active low)
  localparam logic [CODE_W-1:0] NO_KEY    = 6'd63;
  localparam logic [CODE_W-1:0] CODE_KEY1 = 6'd55;
  localparam logic [CODE_W-1:0] CODE_KEY2 = 6'd47;
  localparam logic [CODE_W-1:0] CODE_KEY3 = 6'd31;
  localparam logic [CODE_W-1:0] CODE_KEY4 = 6'd59;
  localparam logic [CODE_W-1:0] CODE_KEY5 = 6'd61;
  localparam logic [CODE_W-1:0] CODE_KEY6 = 6'd62;

  localparam logic [KEY_W-1:0] UNMAPPED_KEY = 3'd0;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] EV_SHORT = 2'd1;
  localparam logic [KIND_W-1:0] EV_LONG  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF    = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd100;
  localparam logic [CFG_W-1:0] SHORT_MIN_RST  = 16'd5;
  localparam logic [CFG_W-1:0] HOLDOFF_RST    = 16'd500;

  typedef struct packed {
    logic [CODE_W-1:0] raw_code;
    logic [TIME_W-1:0] now_ms;
  } kpc_in_t;

  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [KEY_W-1:0]  key_number;
    logic              suppressed;
  } kpc_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] short_min_ticks;
    logic [CFG_W-1:0] holdoff_ms;
  } kpc_cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0]  prev_sample;
    logic [CODE_W-1:0]  held_code;
    logic [COUNT_W-1:0] hold_count;
    logic [KEY_W-1:0]   mapped_key;
    logic [TIME_W-1:0]  last_event_time;
  } kpc_state_t;

  function automatic logic [KEY_W-1:0] map_code(input logic [CODE_W-1:0] code);
    logic [KEY_W-1:0] key;
    unique case (code)
      CODE_KEY1: key = 3'd1;
      CODE_KEY2: key = 3'd2;
      CODE_KEY3: key = 3'd3;
      CODE_KEY4: key = 3'd4;
      CODE_KEY5: key = 3'd5;
      CODE_KEY6: key = 3'd6;
      default:   key = UNMAPPED_KEY;
    endcase
    return key;
  endfunction

endpackage

### rtl/core/kpc_step.sv
`timescale 1ns / 1ps

// One scan tick: next key state and the result beat.
module kpc_step (
  input  kpc_pkg::kpc_in_t    item,
  input  kpc_pkg::kpc_cfg_t   cfg,
  input  kpc_pkg::kpc_state_t st,
  output kpc_pkg::kpc_state_t st_nxt,
  output kpc_pkg::kpc_out_t   result
);

  logic [kpc_pkg::KIND_W-1:0] kind;
  logic [kpc_pkg::KEY_W-1:0]  key;
  logic [kpc_pkg::TIME_W-1:0] gap;
  logic                       stable;
  logic                       released;

  assign stable   = (item.raw_code == st.prev_sample);
  assign released = (item.raw_code == kpc_pkg::NO_KEY);
  assign gap      = item.now_ms - st.last_event_time;

  always_comb begin
    st_nxt = st;
    kind   = kpc_pkg::EV_NONE;
    key    = kpc_pkg::UNMAPPED_KEY;
    result = '0;

    if (!stable) begin
      st_nxt.prev_sample = item.raw_code;
    end else if (released) begin
      if (st.held_code != kpc_pkg::NO_KEY && st.hold_count < cfg.long_press_ticks) begin
        // early release clears the latch only past the short minimum; else it stays untouched
        if (st.hold_count > cfg.short_min_ticks) begin
          st_nxt.held_code  = kpc_pkg::NO_KEY;
          st_nxt.hold_count = '0;
          kind              = kpc_pkg::EV_SHORT;
          key               = st.mapped_key;
        end
      end else begin
        st_nxt.held_code  = kpc_pkg::NO_KEY;
        st_nxt.hold_count = '0;
      end
    end else if (item.raw_code == st.held_code) begin
      if (st.hold_count != kpc_pkg::COUNT_MAX) begin
        st_nxt.hold_count = st.hold_count + 16'd1;
        if (st.hold_count == cfg.long_press_ticks) begin
          kind = kpc_pkg::EV_LONG;
          key  = st.mapped_key;
        end
      end
    end else begin
      st_nxt.held_code  = item.raw_code;
      st_nxt.mapped_key = kpc_pkg::map_code(item.raw_code);
    end

    // Holdoff window: every real event moves the reference time
    if (key != kpc_pkg::UNMAPPED_KEY) begin
      st_nxt.last_event_time = item.now_ms;
      if (gap < {16'd0, cfg.holdoff_ms}) begin
        result.suppressed = 1'b1;
      end else begin
        result.event_kind = kind;
        result.key_number = key;
      end
    end
  end

endmodule

### rtl/core/key_press_classifier_core.sv
`timescale 1ns / 1ps
// Path: an accepted input beat is held in the input register, then in the result register.
// Throughput: one input beat per cycle while the result register drains (out_ready);
//   the state update in the step logic between input register and result register sets that rate.
// Reset (rst_n low, synchronous): registers return to 100/5/500, key state to
//   no key with zero count and time, both pipeline stages empty.
module key_press_classifier_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  kpc_pkg::kpc_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output kpc_pkg::kpc_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [kpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [kpc_pkg::CFG_W-1:0]           cfg_wdata
);

  // Configuration registers
  kpc_pkg::kpc_cfg_t cfg_r, cfg_nxt;

  // Input stage
  kpc_pkg::kpc_in_t  in_r;
  logic              in_vld_r;

  // Key state carried from tick to tick
  kpc_pkg::kpc_state_t st_r, st_nxt;

  // Result stage
  kpc_pkg::kpc_out_t res_r, res_nxt;
  logic              res_vld_r;

  logic advance;  // input stage moves into the result stage this cycle
  logic accept;

  // Advance the input stage whenever the result register is empty or drains now.
  assign advance  = in_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign accept   = in_valid && in_ready;

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  kpc_step u_step (
    .item   (in_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .result (res_nxt)
  );

  // Register writes; an index beyond the list is dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        kpc_pkg::REG_LONG_PRESS: cfg_nxt.long_press_ticks = cfg_wdata;
        kpc_pkg::REG_SHORT_MIN:  cfg_nxt.short_min_ticks  = cfg_wdata;
        kpc_pkg::REG_HOLDOFF:    cfg_nxt.holdoff_ms       = cfg_wdata;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ticks <= kpc_pkg::LONG_PRESS_RST;
      cfg_r.short_min_ticks  <= kpc_pkg::SHORT_MIN_RST;
      cfg_r.holdoff_ms       <= kpc_pkg::HOLDOFF_RST;
      st_r.prev_sample       <= kpc_pkg::NO_KEY;
      st_r.held_code         <= kpc_pkg::NO_KEY;
      st_r.hold_count        <= '0;
      st_r.mapped_key        <= kpc_pkg::UNMAPPED_KEY;
      st_r.last_event_time   <= '0;
      in_vld_r               <= 1'b0;
      res_vld_r              <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      // Capture a new beat or drop the stage once it moved on
      if (accept) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      // Commit key state only with the tick that produces a result
      if (advance) begin
        st_r      <= st_nxt;
        res_vld_r <= 1'b1;
      end else if (out_ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

endmodule
